// ===== design/dfb_pkg.sv =====
`timescale 1ns / 1ps

package dfb_pkg;

	localparam logic [7:0] DLE_CODE = 8'h10;
	localparam logic [7:0] STX_CODE = 8'h02;
	localparam logic [7:0] ETX_CODE = 8'h03;

	localparam logic [7:0] CRC_POLY_RESET = 8'h8C;

	// Depth of the item queue between the front and the back end.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_END   = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t        kind;
		logic [7:0]  frame_type;
		logic [7:0]  channel_number;
		logic [7:0]  sequence_number;
		logic [15:0] declared_size;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	// Reflected CRC-8 over one byte, least significant bit first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] v;
		int         k;
		v = crc ^ b;
		for (k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
		end
		return v;
	endfunction

endpackage

// ===== design/dfb_front.sv =====
`timescale 1ns / 1ps

module dfb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [7:0]         frame_type,
	input  logic [7:0]         channel_number,
	input  logic [7:0]         sequence_number,
	input  logic [15:0]        declared_size,
	input  logic [7:0]         data_byte,
	input  dfb_pkg::q_status_t q_status,
	output logic               push,
	output dfb_pkg::item_t     push_item
);

	logic accept;
	logic keep;
	logic in_frame_q;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	// Payload and end beats outside an open frame are dropped here, as is the unused code.
	always_comb begin
		keep = 1'b0;
		unique case (cmd)
			dfb_pkg::CMD_START: keep = 1'b1;
			dfb_pkg::CMD_DATA:  keep = in_frame_q;
			dfb_pkg::CMD_END:   keep = in_frame_q;
			default:            keep = 1'b0;
		endcase
	end

	assign push                     = accept && keep;
	assign push_item.kind           = dfb_pkg::cmd_t'(cmd);
	assign push_item.frame_type     = frame_type;
	assign push_item.channel_number = channel_number;
	assign push_item.sequence_number = sequence_number;
	assign push_item.declared_size  = declared_size;
	assign push_item.data_byte      = data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (accept) begin
			if (cmd == dfb_pkg::CMD_START) begin
				in_frame_q <= 1'b1;
			end else if (cmd == dfb_pkg::CMD_END) begin
				in_frame_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/dfb_queue.sv =====
`timescale 1ns / 1ps

module dfb_queue #(
	parameter int DEPTH = dfb_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dfb_pkg::item_t     push_item,
	input  logic               pop,
	output dfb_pkg::item_t     head_item,
	output dfb_pkg::q_status_t q_status
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	dfb_pkg::item_t mem [DEPTH];

	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_do;
	logic             pop_do;

	assign q_status.full      = (count_q == CNT_W'(DEPTH));
	assign q_status.not_empty = (count_q != '0);
	assign push_do            = push && !q_status.full;
	assign pop_do             = pop && q_status.not_empty;
	assign head_item          = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_do) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_do) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_do) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_do && !pop_do) begin
				count_q <= count_q + 1'b1;
			end else if (pop_do && !push_do) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/dfb_back.sv =====
`timescale 1ns / 1ps

module dfb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         crc_polynomial,
	input  dfb_pkg::q_status_t q_status,
	input  dfb_pkg::item_t     head_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_of_run,
	output logic               frame_end
);

	typedef enum logic [3:0] {
		ST_DLE,
		ST_STX,
		ST_TYPE,
		ST_CHAN,
		ST_SEQ,
		ST_SIZE_HI,
		ST_SIZE_LO,
		ST_DATA,
		ST_CRC,
		ST_CLOSE_DLE,
		ST_ETX
	} step_t;

	logic           busy_q;
	step_t          step_q;
	logic           dup_q;
	dfb_pkg::item_t cur_q;
	logic [7:0]     crc_q;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           out_last_q;
	logic           out_end_q;

	logic       emit;
	logic [7:0] byte_sel;
	logic       escaped;
	logic       feed_crc;
	logic       clear_crc;
	logic       final_step;
	logic       end_flag;
	step_t      next_step;
	step_t      first_step;
	logic       hold;
	logic       item_done;

	assign emit = busy_q && (!out_valid_q || out_ready);

	always_comb begin
		byte_sel   = dfb_pkg::DLE_CODE;
		escaped    = 1'b0;
		feed_crc   = 1'b0;
		clear_crc  = 1'b0;
		final_step = 1'b0;
		end_flag   = 1'b0;
		next_step  = ST_DLE;
		unique case (step_q)
			ST_DLE: begin
				byte_sel  = dfb_pkg::DLE_CODE;
				clear_crc = 1'b1;
				next_step = ST_STX;
			end
			ST_STX: begin
				byte_sel  = dfb_pkg::STX_CODE;
				next_step = ST_TYPE;
			end
			ST_TYPE: begin
				byte_sel  = cur_q.frame_type;
				feed_crc  = 1'b1;
				next_step = ST_CHAN;
			end
			ST_CHAN: begin
				byte_sel  = cur_q.channel_number;
				feed_crc  = 1'b1;
				next_step = ST_SEQ;
			end
			ST_SEQ: begin
				byte_sel  = cur_q.sequence_number;
				escaped   = 1'b1;
				feed_crc  = 1'b1;
				next_step = ST_SIZE_HI;
			end
			ST_SIZE_HI: begin
				byte_sel  = cur_q.declared_size[15:8];
				escaped   = 1'b1;
				feed_crc  = 1'b1;
				next_step = ST_SIZE_LO;
			end
			ST_SIZE_LO: begin
				byte_sel   = cur_q.declared_size[7:0];
				escaped    = 1'b1;
				feed_crc   = 1'b1;
				final_step = 1'b1;
			end
			ST_DATA: begin
				byte_sel   = cur_q.data_byte;
				escaped    = 1'b1;
				feed_crc   = 1'b1;
				final_step = 1'b1;
			end
			ST_CRC: begin
				byte_sel  = crc_q;
				escaped   = 1'b1;
				next_step = ST_CLOSE_DLE;
			end
			ST_CLOSE_DLE: begin
				byte_sel  = dfb_pkg::DLE_CODE;
				next_step = ST_ETX;
			end
			ST_ETX: begin
				byte_sel   = dfb_pkg::ETX_CODE;
				final_step = 1'b1;
				end_flag   = 1'b1;
			end
			default: begin
				next_step = ST_DLE;
			end
		endcase
	end

	// An escaped DLE stays on its step for one more beat; the copy does not enter the CRC.
	assign hold      = escaped && !dup_q && (byte_sel == dfb_pkg::DLE_CODE);
	assign item_done = final_step && !hold;
	assign pop       = q_status.not_empty && (!busy_q || (emit && item_done));

	always_comb begin
		unique case (head_item.kind)
			dfb_pkg::CMD_START: first_step = ST_DLE;
			dfb_pkg::CMD_DATA:  first_step = ST_DATA;
			dfb_pkg::CMD_END:   first_step = ST_CRC;
			default:            first_step = ST_DATA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= ST_DLE;
			dup_q       <= 1'b0;
			cur_q       <= '0;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_end_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= byte_sel;
				out_last_q  <= item_done;
				out_end_q   <= end_flag;
				dup_q       <= hold;
				if (clear_crc) begin
					crc_q <= '0;
				end else if (feed_crc && !dup_q) begin
					crc_q <= dfb_pkg::crc8_update(crc_q, byte_sel, crc_polynomial);
				end
				if (!hold) begin
					step_q <= next_step;
				end
			end
			if (pop) begin
				cur_q  <= head_item;
				step_q <= first_step;
				dup_q  <= 1'b0;
				busy_q <= 1'b1;
			end else if (emit && item_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;
	assign frame_end   = out_end_q;

endmodule

// ===== design/dle_escaped_frame_builder.sv =====
`timescale 1ns / 1ps

// Byte-stuffing frame builder. Input beats (cmd plus header or payload fields) arrive on the
// in_valid/in_ready channel; the framed byte stream leaves one byte per beat on the
// out_valid/out_ready channel, with last_of_run marking the final byte of each input item and
// frame_end marking the closing ETX. cfg_write_en/cfg_write_data load the CRC polynomial and
// should only be used while the block is idle.
// The front end tracks whether a frame is open and drops payload and end items outside one;
// kept items wait in a small queue, so input is taken while the output is stalled until the
// queue fills. The back end sequencer produces one byte per cycle while busy and not held by
// out_ready, which sets the rate: a payload item yields 1 byte (2 when the byte equals DLE), a
// start item 7 to 10 bytes and an end item 3 or 4 bytes. With the block empty, an accepted beat
// is written to the queue and popped into the back end before its first byte is registered. The
// output holds its byte while out_ready is low and the back end waits; nothing is lost. Reset
// closes any open frame, clears the CRC, empties the queue and restores the default polynomial.
module dle_escaped_frame_builder #(
	parameter int QUEUE_DEPTH = dfb_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [7:0]  cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  frame_type,
	input  logic [7:0]  channel_number,
	input  logic [7:0]  sequence_number,
	input  logic [15:0] declared_size,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        frame_end
);

	logic [7:0]         poly_q;
	logic               q_push;
	logic               q_pop;
	dfb_pkg::item_t     q_in_item;
	dfb_pkg::item_t     q_head_item;
	dfb_pkg::q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= dfb_pkg::CRC_POLY_RESET;
		end else if (cfg_write_en) begin
			poly_q <= cfg_write_data;
		end
	end

	dfb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.frame_type      (frame_type),
		.channel_number  (channel_number),
		.sequence_number (sequence_number),
		.declared_size   (declared_size),
		.data_byte       (data_byte),
		.q_status        (q_status),
		.push            (q_push),
		.push_item       (q_in_item)
	);

	dfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in_item),
		.pop       (q_pop),
		.head_item (q_head_item),
		.q_status  (q_status)
	);

	dfb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.crc_polynomial (poly_q),
		.q_status       (q_status),
		.head_item      (q_head_item),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.last_of_run    (last_of_run),
		.frame_end      (frame_end)
	);

	// The front end must never push into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_status.full)
		else $error("item pushed into a full queue");

	// The closing ETX always ends the run of its end item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (last_of_run && out_byte == dfb_pkg::ETX_CODE))
		else $error("frame end flag on a byte that is not the closing ETX");

	// The queue is only popped when it holds an item.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_status.not_empty)
		else $error("pop from an empty queue");

endmodule
